// ===== rtl/lmfbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame buffer scanner package
// Shared sizes, item opcodes and sequencer states.
// ----------------------------------------------------------------------------
package lmfbs_pkg;

    // Number of cascaded 8x8 modules in the chain (1 to 8).
    localparam int MODULES = 4;
    // One byte per column, eight columns per module.
    localparam int COLS    = 8 * MODULES;
    localparam int ADDR_W  = $clog2(COLS);

    typedef enum logic [2:0] {
        OP_PIXEL       = 3'd0,
        OP_COLUMN      = 3'd1,
        OP_ROW         = 3'd2,
        OP_CLEAR_SHOWN = 3'd3,
        OP_REFRESH     = 3'd4,
        OP_COPY        = 3'd5,
        OP_CLEAR_DRAW  = 3'd6,
        OP_COMMIT      = 3'd7
    } t_op;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_CLR  = 7'b0000100,
        S_COPY = 7'b0001000,
        S_ROW  = 7'b0010000,
        S_REF  = 7'b0100000,
        S_WAIT = 7'b1000000
    } t_state;

endpackage

// ===== rtl/lmfbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel bank RAM
// One byte per column, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lmfbs_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [lmfbs_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [7:0]                    i_wdata,
    input  logic [lmfbs_pkg::ADDR_W-1:0]  i_raddr,
    output logic [7:0]                    o_rdata
);

    logic [7:0] r_mem [lmfbs_pkg::COLS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/led_matrix_frame_buffer_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame buffer scanner
// Double-buffered pixel store for a chain of 8x8 LED matrix drivers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at the clock edge where start is high
//   and busy is low. Result channel: each row byte is on the o_ ports for
//   exactly one cycle with o_valid high; the receiver cannot hold it off.
//   Busy states per command (COLS = 8 * MODULES columns):
//     column write       none (a word every cycle)
//     pixel write        S_WAIT (read-modify-write of one column byte)
//     clear shown/draw   S_CLR over all COLS (one zero write per cycle)
//     copy, row write    S_COPY/S_ROW, S_WAIT (read, modify, write back one column a cycle)
//     refresh, commit    S_REF, S_WAIT
//   A refresh walks rows 0..7 and modules last to first; each byte gathers
//   one bit from eight column bytes, read one at a time through the single
//   read port of the shown bank.
//   Commit swaps the shown and draw banks, then refreshes the new shown bank.
//   Reset: busy stays high in S_INIT while both banks are zeroed,
//   one column per cycle; the shown bank is bank A afterwards.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_op,
    input  logic       i_target,
    input  logic [5:0] i_column,
    input  logic [2:0] i_row,
    input  logic       i_pixel_on,
    input  logic [7:0] i_value,
    output logic       o_valid,
    output logic [3:0] o_digit_register,
    output logic [7:0] o_row_bits,
    output logic [2:0] o_module_index,
    output logic       o_chain_end,
    output logic       o_last
);

    localparam int AW = lmfbs_pkg::ADDR_W;
    localparam logic [AW-1:0] ADDR_LAST = AW'(lmfbs_pkg::COLS - 1);
    localparam logic [2:0]    MOD_LAST  = 3'(lmfbs_pkg::MODULES - 1);

    // Sequencer and sweep control
    lmfbs_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_shown_is_b, n_shown_is_b;
    logic              r_bank, n_bank;        // bank read (and written, except copy)

    // Read return stage: tags of the read issued last cycle
    logic              r_ret_vld, n_ret_vld;
    lmfbs_pkg::t_op    r_ret_op, n_ret_op;
    logic [AW-1:0]     r_ret_addr, n_ret_addr;
    logic [2:0]        r_ret_row, n_ret_row;
    logic [2:0]        r_ret_mod, n_ret_mod;
    logic [2:0]        r_ret_col, n_ret_col;

    // Refresh issue position
    logic [2:0]        r_iss_row, n_iss_row;
    logic [2:0]        r_iss_mod, n_iss_mod;
    logic [2:0]        r_iss_col, n_iss_col;

    // Held command operands and byte gather
    logic [2:0]        r_row, n_row;
    logic              r_pixel_on, n_pixel_on;
    logic [7:0]        r_value, n_value;
    logic [7:0]        r_bits, n_bits;

    // Result register
    logic              r_valid, n_valid;
    logic [3:0]        r_digit, n_digit;
    logic [7:0]        r_row_bits, n_row_bits;
    logic [2:0]        r_mod_out, n_mod_out;
    logic              r_chain_end, n_chain_end;
    logic              r_last, n_last;

    // Memory ports
    logic              w_we_a, w_we_b;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [7:0]        w_wdata;
    logic [7:0]        w_rdata_a, w_rdata_b, w_rdata, w_mod;

    lmfbs_pkg::t_op    w_op;
    logic              w_accept;
    logic              w_col_ok;

    lmfbs_ram u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_a)
    );

    lmfbs_ram u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_b)
    );

    assign w_op     = lmfbs_pkg::t_op'(i_op);
    assign w_accept = start && (r_state == lmfbs_pkg::S_IDLE);
    assign w_col_ok = {1'b0, i_column} < 7'(lmfbs_pkg::COLS);
    assign w_rdata  = r_bank ? w_rdata_b : w_rdata_a;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_shown_is_b = r_shown_is_b;
        n_bank       = r_bank;
        n_ret_vld    = 1'b0;
        n_ret_op     = r_ret_op;
        n_ret_addr   = r_ret_addr;
        n_ret_row    = r_ret_row;
        n_ret_mod    = r_ret_mod;
        n_ret_col    = r_ret_col;
        n_iss_row    = r_iss_row;
        n_iss_mod    = r_iss_mod;
        n_iss_col    = r_iss_col;
        n_row        = r_row;
        n_pixel_on   = r_pixel_on;
        n_value      = r_value;
        n_bits       = r_bits;
        n_valid      = 1'b0;
        n_digit      = r_digit;
        n_row_bits   = r_row_bits;
        n_mod_out    = r_mod_out;
        n_chain_end  = r_chain_end;
        n_last       = r_last;
        w_we_a       = 1'b0;
        w_we_b       = 1'b0;
        w_waddr      = r_ret_addr;
        w_wdata      = '0;
        w_raddr      = r_addr;
        w_mod        = w_rdata;

        // Finish the read issued last cycle: modify and write back, or gather.
        if (r_ret_vld) begin
            case (r_ret_op)
                lmfbs_pkg::OP_PIXEL: begin
                    w_mod[~r_row] = r_pixel_on;
                    w_wdata = w_mod;
                    w_we_a  = !r_bank;
                    w_we_b  = r_bank;
                end
                lmfbs_pkg::OP_ROW: begin
                    // row pattern bit 7 lands on column 0 of every module
                    w_mod[~r_row] = r_value[~r_ret_addr[2:0]];
                    w_wdata = w_mod;
                    w_we_a  = !r_bank;
                    w_we_b  = r_bank;
                end
                lmfbs_pkg::OP_COPY: begin
                    w_wdata = w_rdata;
                    w_we_a  = r_bank;
                    w_we_b  = !r_bank;
                end
                lmfbs_pkg::OP_REFRESH: begin
                    if (r_ret_col == 3'd0) begin
                        n_bits = '0;
                    end
                    n_bits[r_ret_col] = w_rdata[~r_ret_row];
                    if (r_ret_col == 3'd7) begin
                        n_valid     = 1'b1;
                        n_digit     = {1'b0, r_ret_row} + 4'd1;
                        n_row_bits  = n_bits;
                        n_mod_out   = r_ret_mod;
                        n_chain_end = (r_ret_mod == 3'd0);
                        n_last      = (r_ret_mod == 3'd0) && (r_ret_row == 3'd7);
                    end
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            lmfbs_pkg::S_INIT: begin
                w_we_a  = 1'b1;
                w_we_b  = 1'b1;
                w_waddr = r_addr;
                w_wdata = '0;
                n_addr  = r_addr + 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = lmfbs_pkg::S_IDLE;
                end
            end
            lmfbs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_addr = '0;
                    case (w_op)
                        lmfbs_pkg::OP_PIXEL: begin
                            if (w_col_ok) begin
                                w_raddr    = i_column[AW-1:0];
                                n_ret_vld  = 1'b1;
                                n_ret_op   = lmfbs_pkg::OP_PIXEL;
                                n_ret_addr = i_column[AW-1:0];
                                n_bank     = r_shown_is_b ^ i_target;
                                n_row      = i_row;
                                n_pixel_on = i_pixel_on;
                                n_state    = lmfbs_pkg::S_WAIT;
                            end
                        end
                        lmfbs_pkg::OP_COLUMN: begin
                            if (w_col_ok) begin
                                w_waddr = i_column[AW-1:0];
                                w_wdata = i_value;
                                w_we_a  = !(r_shown_is_b ^ i_target);
                                w_we_b  = r_shown_is_b ^ i_target;
                            end
                        end
                        lmfbs_pkg::OP_ROW: begin
                            n_bank  = r_shown_is_b;
                            n_row   = i_row;
                            n_value = i_value;
                            n_state = lmfbs_pkg::S_ROW;
                        end
                        lmfbs_pkg::OP_CLEAR_SHOWN: begin
                            n_bank  = r_shown_is_b;
                            n_state = lmfbs_pkg::S_CLR;
                        end
                        lmfbs_pkg::OP_CLEAR_DRAW: begin
                            n_bank  = !r_shown_is_b;
                            n_state = lmfbs_pkg::S_CLR;
                        end
                        lmfbs_pkg::OP_COPY: begin
                            n_bank  = r_shown_is_b;
                            n_state = lmfbs_pkg::S_COPY;
                        end
                        lmfbs_pkg::OP_REFRESH: begin
                            n_bank    = r_shown_is_b;
                            n_iss_row = '0;
                            n_iss_mod = MOD_LAST;
                            n_iss_col = '0;
                            n_state   = lmfbs_pkg::S_REF;
                        end
                        lmfbs_pkg::OP_COMMIT: begin
                            n_shown_is_b = !r_shown_is_b;
                            n_bank       = !r_shown_is_b;
                            n_iss_row    = '0;
                            n_iss_mod    = MOD_LAST;
                            n_iss_col    = '0;
                            n_state      = lmfbs_pkg::S_REF;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lmfbs_pkg::S_CLR: begin
                w_waddr = r_addr;
                w_wdata = '0;
                w_we_a  = !r_bank;
                w_we_b  = r_bank;
                n_addr  = r_addr + 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = lmfbs_pkg::S_IDLE;
                end
            end
            lmfbs_pkg::S_COPY, lmfbs_pkg::S_ROW: begin
                w_raddr    = r_addr;
                n_ret_vld  = 1'b1;
                n_ret_op   = (r_state == lmfbs_pkg::S_COPY) ? lmfbs_pkg::OP_COPY
                                                            : lmfbs_pkg::OP_ROW;
                n_ret_addr = r_addr;
                n_addr     = r_addr + 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = lmfbs_pkg::S_WAIT;
                end
            end
            lmfbs_pkg::S_REF: begin
                // column byte m*8+c carries bit (7-r) of row r
                w_raddr   = AW'({r_iss_mod, r_iss_col});
                n_ret_vld = 1'b1;
                n_ret_op  = lmfbs_pkg::OP_REFRESH;
                n_ret_row = r_iss_row;
                n_ret_mod = r_iss_mod;
                n_ret_col = r_iss_col;
                n_iss_col = r_iss_col + 3'd1;
                if (r_iss_col == 3'd7) begin
                    if (r_iss_mod == 3'd0) begin
                        n_iss_mod = MOD_LAST;
                        n_iss_row = r_iss_row + 3'd1;
                        if (r_iss_row == 3'd7) begin
                            n_state = lmfbs_pkg::S_WAIT;
                        end
                    end else begin
                        n_iss_mod = r_iss_mod - 3'd1;
                    end
                end
            end
            lmfbs_pkg::S_WAIT: begin
                // last read returns this cycle
                n_state = lmfbs_pkg::S_IDLE;
            end
            default: begin
                n_state = lmfbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lmfbs_pkg::S_INIT;
            r_addr       <= '0;
            r_shown_is_b <= 1'b0;
            r_ret_vld    <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_shown_is_b <= n_shown_is_b;
            r_ret_vld    <= n_ret_vld;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank      <= n_bank;
        r_ret_op    <= n_ret_op;
        r_ret_addr  <= n_ret_addr;
        r_ret_row   <= n_ret_row;
        r_ret_mod   <= n_ret_mod;
        r_ret_col   <= n_ret_col;
        r_iss_row   <= n_iss_row;
        r_iss_mod   <= n_iss_mod;
        r_iss_col   <= n_iss_col;
        r_row       <= n_row;
        r_pixel_on  <= n_pixel_on;
        r_value     <= n_value;
        r_bits      <= n_bits;
        r_digit     <= n_digit;
        r_row_bits  <= n_row_bits;
        r_mod_out   <= n_mod_out;
        r_chain_end <= n_chain_end;
        r_last      <= n_last;
    end

    assign busy             = (r_state != lmfbs_pkg::S_IDLE);
    assign o_valid          = r_valid;
    assign o_digit_register = r_digit;
    assign o_row_bits       = r_row_bits;
    assign o_module_index   = r_mod_out;
    assign o_chain_end      = r_chain_end;
    assign o_last           = r_last;

    // A byte only leaves from a refresh walk.
    a_valid_from_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == lmfbs_pkg::S_REF
                  || $past(r_state) == lmfbs_pkg::S_WAIT))
        else $error("result strobe outside a refresh");

    // The final byte of a refresh also closes its row.
    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_chain_end && o_digit_register == 4'd8))
        else $error("last byte not at end of row eight");

    // No read is left pending once the block reports idle.
    a_idle_no_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_ret_vld)
        else $error("pending read while idle");

    // Commit swaps the bank roles.
    a_commit_swaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == lmfbs_pkg::OP_COMMIT)
        |=> (r_shown_is_b != $past(r_shown_is_b)))
        else $error("commit did not swap banks");

endmodule

// ===== tb/led_matrix_frame_buffer_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix frame buffer scanner testbench
// Sends pixel, column, row, clear, copy, refresh and commit words and checks
// every row byte of each refresh against a model of the two frame banks.
// ----------------------------------------------------------------------------
module led_matrix_frame_buffer_scanner_tb;

    // Longest run of cycles with no word taken and no row byte leaving.
    localparam int STALL_LIMIT = 2000;
    // A refresh keeps the block busy while it walks every row of every module.
    localparam int SETTLE_CYCLES = 8 * lmfbs_pkg::COLS + 40;

    typedef struct packed {
        logic [3:0] digit;
        logic [7:0] bits;
        logic [2:0] module_idx;
        logic       chain_end;
        logic       final_byte;
    } t_row_byte;

    // Models both banks and the shown/draw swap; holds the row bytes that
    // the refreshes in flight still owe.
    class t_frame_store_predictor;
        logic [7:0] bank [2][lmfbs_pkg::COLS];
        bit         shown_sel;
        t_row_byte  owed_bytes [$];
        int         mismatches;
        int         bytes_checked;
        int         words_by_op [8];

        function new();
            foreach (bank[b, c]) bank[b][c] = 8'h00;
            shown_sel     = 1'b0;
            mismatches    = 0;
            bytes_checked = 0;
            foreach (words_by_op[i]) words_by_op[i] = 0;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH at %0t, byte %0d: %s got 0x%0h want 0x%0h",
                     $time, bytes_checked, what, got, want);
            mismatches++;
        endtask

        // Queue one byte per module per row, rows 0..7, last module first.
        function void scan_shown();
            t_row_byte rb;
            for (int r = 0; r < 8; r++) begin
                for (int m = lmfbs_pkg::MODULES - 1; m >= 0; m--) begin
                    rb.digit      = 4'(r + 1);
                    rb.module_idx = 3'(m);
                    rb.chain_end  = (m == 0);
                    rb.final_byte = (m == 0) && (r == 7);
                    for (int c = 0; c < 8; c++)
                        rb.bits[c] = bank[shown_sel][m * 8 + c][7 - r];
                    owed_bytes.push_back(rb);
                end
            end
        endfunction

        function void note_word(lmfbs_pkg::t_op op, bit target, logic [5:0] column,
                                logic [2:0] row, bit pixel_on, logic [7:0] value);
            int dst;
            int col;
            dst = target ? int'(!shown_sel) : int'(shown_sel);
            col = int'(column);
            words_by_op[op]++;
            case (op)
                lmfbs_pkg::OP_PIXEL: begin
                    if (col < lmfbs_pkg::COLS) bank[dst][col][7 - row] = pixel_on;
                end
                lmfbs_pkg::OP_COLUMN: begin
                    if (col < lmfbs_pkg::COLS) bank[dst][col] = value;
                end
                lmfbs_pkg::OP_ROW: begin
                    // Same pattern in every module, always into the shown bank.
                    for (int c = 0; c < lmfbs_pkg::COLS; c++)
                        bank[shown_sel][c][7 - row] = value[7 - (c % 8)];
                end
                lmfbs_pkg::OP_CLEAR_SHOWN: begin
                    for (int c = 0; c < lmfbs_pkg::COLS; c++) bank[shown_sel][c] = 8'h00;
                end
                lmfbs_pkg::OP_REFRESH: scan_shown();
                lmfbs_pkg::OP_COPY: begin
                    for (int c = 0; c < lmfbs_pkg::COLS; c++)
                        bank[!shown_sel][c] = bank[shown_sel][c];
                end
                lmfbs_pkg::OP_CLEAR_DRAW: begin
                    for (int c = 0; c < lmfbs_pkg::COLS; c++) bank[!shown_sel][c] = 8'h00;
                end
                default: begin
                    shown_sel = !shown_sel;
                    scan_shown();
                end
            endcase
        endfunction

        task check_row_byte(logic [3:0] digit, logic [7:0] bits,
                            logic [2:0] module_idx, logic chain_end,
                            logic final_byte);
            t_row_byte want;
            if (owed_bytes.size() == 0) begin
                report_mismatch("unexpected row byte, digit", digit, 0);
                return;
            end
            want = owed_bytes.pop_front();
            if (digit !== want.digit)
                report_mismatch("digit register", digit, want.digit);
            if (bits !== want.bits)
                report_mismatch("row bits", bits, want.bits);
            if (module_idx !== want.module_idx)
                report_mismatch("module index", module_idx, want.module_idx);
            if (chain_end !== want.chain_end)
                report_mismatch("chain end", chain_end, want.chain_end);
            if (final_byte !== want.final_byte)
                report_mismatch("last", final_byte, want.final_byte);
            bytes_checked++;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_op;
    logic       i_target;
    logic [5:0] i_column;
    logic [2:0] i_row;
    logic       i_pixel_on;
    logic [7:0] i_value;
    logic       o_valid;
    logic [3:0] o_digit_register;
    logic [7:0] o_row_bits;
    logic [2:0] o_module_index;
    logic       o_chain_end;
    logic       o_last;

    t_frame_store_predictor frame_model = new();
    int idle_pct;
    int quiet_cycles = 0;

    led_matrix_frame_buffer_scanner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_target         (i_target),
        .i_column         (i_column),
        .i_row            (i_row),
        .i_pixel_on       (i_pixel_on),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .o_digit_register (o_digit_register),
        .o_row_bits       (o_row_bits),
        .o_module_index   (o_module_index),
        .o_chain_end      (o_chain_end),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Check each row byte on the edge that ends its strobe cycle, and guard
    // against a hang: count cycles where no word is taken and nothing leaves.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            frame_model.check_row_byte(o_digit_register, o_row_bits, o_module_index,
                                       o_chain_end, o_last);
        if ((start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no progress for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Drive one word and hold it until the block takes it. Start stays high
    // on return so back-to-back words need no extra assignment.
    task automatic send_word(input lmfbs_pkg::t_op op, input bit target,
                             input logic [5:0] column, input logic [2:0] row,
                             input bit pixel_on, input logic [7:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_target   <= target;
        i_column   <= column;
        i_row      <= row;
        i_pixel_on <= pixel_on;
        i_value    <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        frame_model.note_word(op, target, column, row, pixel_on, value);
    endtask

    // Drop start and hold off until every owed row byte has left.
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (frame_model.owed_bytes.size() != 0);
    endtask

    // Mostly writes, with enough refreshes and commits to show the banks
    // often; columns lean toward the valid range but hit the ignored ones too.
    task automatic send_random_word();
        int              pick;
        lmfbs_pkg::t_op  op;
        logic [5:0]      column;
        pick = $urandom_range(99);
        if (pick < 28)      op = lmfbs_pkg::OP_PIXEL;
        else if (pick < 52) op = lmfbs_pkg::OP_COLUMN;
        else if (pick < 62) op = lmfbs_pkg::OP_ROW;
        else if (pick < 67) op = lmfbs_pkg::OP_CLEAR_SHOWN;
        else if (pick < 78) op = lmfbs_pkg::OP_REFRESH;
        else if (pick < 84) op = lmfbs_pkg::OP_COPY;
        else if (pick < 89) op = lmfbs_pkg::OP_CLEAR_DRAW;
        else                op = lmfbs_pkg::OP_COMMIT;
        if ($urandom_range(3) == 0)
            column = 6'($urandom_range(63));
        else
            column = 6'($urandom_range(lmfbs_pkg::COLS - 1));
        send_word(op, 1'($urandom_range(1)), column, 3'($urandom_range(7)),
                  1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_op         = lmfbs_pkg::OP_PIXEL;
        i_target     = 1'b0;
        i_column     = 6'd0;
        i_row        = 3'd0;
        i_pixel_on   = 1'b0;
        i_value      = 8'h00;
        idle_pct     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corner pixels in both banks, full and empty columns,
        // ignored columns, row patterns with a stray target, then every
        // bulk op with refreshes to expose the result.
        send_word(lmfbs_pkg::OP_REFRESH,     1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_PIXEL,       1'b0, 6'd0,  3'd0, 1'b1, 8'h00);
        send_word(lmfbs_pkg::OP_PIXEL,       1'b0, 6'd31, 3'd7, 1'b1, 8'hFF);
        send_word(lmfbs_pkg::OP_PIXEL,       1'b1, 6'd31, 3'd0, 1'b1, 8'h00);
        send_word(lmfbs_pkg::OP_COLUMN,      1'b0, 6'd8,  3'd0, 1'b0, 8'hFF);
        send_word(lmfbs_pkg::OP_COLUMN,      1'b1, 6'd0,  3'd7, 1'b1, 8'hA5);
        send_word(lmfbs_pkg::OP_PIXEL,       1'b0, 6'd32, 3'd3, 1'b1, 8'hFF);
        send_word(lmfbs_pkg::OP_COLUMN,      1'b0, 6'd63, 3'd0, 1'b0, 8'hFF);
        send_word(lmfbs_pkg::OP_PIXEL,       1'b1, 6'd63, 3'd5, 1'b1, 8'h00);
        send_word(lmfbs_pkg::OP_REFRESH,     1'b1, 6'd63, 3'd7, 1'b1, 8'hFF);
        send_word(lmfbs_pkg::OP_ROW,         1'b1, 6'd5,  3'd0, 1'b1, 8'h80);
        send_word(lmfbs_pkg::OP_ROW,         1'b0, 6'd0,  3'd7, 1'b0, 8'hFF);
        send_word(lmfbs_pkg::OP_PIXEL,       1'b0, 6'd8,  3'd7, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_REFRESH,     1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_COMMIT,      1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_COPY,        1'b1, 6'd17, 3'd2, 1'b1, 8'h3C);
        send_word(lmfbs_pkg::OP_CLEAR_SHOWN, 1'b1, 6'd63, 3'd7, 1'b1, 8'hFF);
        send_word(lmfbs_pkg::OP_REFRESH,     1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_COMMIT,      1'b1, 6'd42, 3'd4, 1'b0, 8'h5A);
        send_word(lmfbs_pkg::OP_CLEAR_DRAW,  1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_COLUMN,      1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        send_word(lmfbs_pkg::OP_COMMIT,      1'b0, 6'd0,  3'd0, 1'b0, 8'h00);
        wait_for_drain();

        // Random: sender idles sometimes, then often, then never.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 26 : (phase == 1) ? 78 : 0;
            for (int n = 0; n < 46; n++) begin
                send_random_word();
                if (phase == 0 && n == 23) wait_for_drain();
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d pixel, %0d column, %0d row, %0d clear-shown,",
                 frame_model.words_by_op[lmfbs_pkg::OP_PIXEL],
                 frame_model.words_by_op[lmfbs_pkg::OP_COLUMN],
                 frame_model.words_by_op[lmfbs_pkg::OP_ROW],
                 frame_model.words_by_op[lmfbs_pkg::OP_CLEAR_SHOWN]);
        $display("%0d copy, %0d clear-draw words; %0d refreshes and %0d commits",
                 frame_model.words_by_op[lmfbs_pkg::OP_COPY],
                 frame_model.words_by_op[lmfbs_pkg::OP_CLEAR_DRAW],
                 frame_model.words_by_op[lmfbs_pkg::OP_REFRESH],
                 frame_model.words_by_op[lmfbs_pkg::OP_COMMIT]);
        $display("scanned out %0d row bytes, %0d mismatches.",
                 frame_model.bytes_checked, frame_model.mismatches);
        if (frame_model.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
